### hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants shared by the source token scanner modules.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned ResultDepth = 4;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_INT,
    MODE_HEX_START,
    MODE_HEX,
    MODE_FRAC_START,
    MODE_FRAC,
    MODE_EXP_START,
    MODE_EXP_SIGN,
    MODE_EXP,
    MODE_IDENT
  } mode_e;

  typedef enum logic [2:0] {
    KIND_END,
    KIND_COMMENT,
    KIND_STRING,
    KIND_INT,
    KIND_DEC,
    KIND_IDENT,
    KIND_PUNCT,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_CHAR,
    ERR_EOF_STRING,
    ERR_INT_LETTER,
    ERR_NO_FRACTION,
    ERR_SECOND_POINT,
    ERR_NO_EXP_DIGITS,
    ERR_NO_HEX_DIGIT
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  punct;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    err_e        err;
    logic        last;
  } result_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] tok_line;
    logic [15:0] tok_column;
    logic [15:0] tok_bytes;
    logic        lead_zero;
    logic        err_latched;
  } scan_state_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } step_out_t;

  localparam scan_state_t StateReset = '{
    mode:        MODE_IDLE,
    line:        16'd1,
    column:      16'd1,
    tok_line:    16'd1,
    tok_column:  16'd1,
    tok_bytes:   16'd0,
    lead_zero:   1'b0,
    err_latched: 1'b0
  };

endpackage

### hdl/source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// source_token_scanner_core
// Byte-at-a-time lexical scanner reporting kind, length and start position
// of each token.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  input    in         in_valid_i/in_stall_o char_in_i, end_of_input_i
//  result   out        out_valid_o/out_stall_i token_kind_o .. last_of_run_o
//
//  One item per cycle unless in_stall_o is high; the scan step is one
//  pass of logic from the state registers into the result queue, which
//  registers each result at its transfer. Reset clears the scan state
//  and empties the queue; the input stalls while under two entries are free.
// ----------------------------------------------------------------------------
module source_token_scanner_core #(
  parameter int unsigned ResultDepth = sts_pkg::ResultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  punct_char_o,
  output logic [15:0] token_length_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  sts_pkg::scan_state_t state_q, state_d;
  sts_pkg::step_out_t   step;
  sts_pkg::result_t     head;
  logic                 full;
  logic                 in_xfer;

  assign in_stall_o = full;
  assign in_xfer    = in_valid_i && !full;

  sts_step u_step (
    .cur_i  (state_q),
    .char_i (char_in_i),
    .eoi_i  (end_of_input_i),
    .nxt_o  (state_d),
    .out_o  (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sts_pkg::StateReset;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  sts_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_xfer),
    .wr_i       (step),
    .full_o     (full),
    .rd_valid_o (out_valid_o),
    .rd_en_i    (!out_stall_i),
    .rd_o       (head)
  );

  assign token_kind_o   = head.kind;
  assign punct_char_o   = head.punct;
  assign token_length_o = head.length;
  assign start_line_o   = head.line;
  assign start_column_o = head.column;
  assign error_code_o   = head.err;
  assign last_of_run_o  = head.last;

endmodule

### hdl/sts_step.sv
// ----------------------------------------------------------------------------
// sts_step
// Next-state and result logic for one source byte or end-of-input mark.
// ----------------------------------------------------------------------------
module sts_step (
  input  sts_pkg::scan_state_t cur_i,
  input  logic [7:0]           char_i,
  input  logic                 eoi_i,
  output sts_pkg::scan_state_t nxt_o,
  output sts_pkg::step_out_t   out_o
);

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == "%") || (c == "&") || (c == "(") || (c == ")") || (c == "*") ||
           (c == "+") || (c == ",") || (c == "-") || (c == ".") || (c == "/") ||
           (c == ":") || (c == ";") || (c == "<") || (c == "=") || (c == ">") ||
           (c == "?") || (c == "[") || (c == 8'h5C) || (c == "]") || (c == "^") ||
           (c == "{") || (c == "}");
  endfunction

  sts_pkg::scan_state_t s;
  sts_pkg::result_t     res [2];
  sts_pkg::result_t     r;
  logic [1:0]           cnt;
  logic [15:0]          ln;
  logic [15:0]          col;
  logic                 again;
  logic                 have_res;
  logic                 do_tok;
  logic                 do_err;
  sts_pkg::kind_e       tok_kind;
  sts_pkg::err_e        err_code;

  always_comb begin
    s        = cur_i;
    res[0]   = '0;
    res[1]   = '0;
    r        = '0;
    cnt      = 2'd0;
    ln       = cur_i.line;
    col      = cur_i.column;
    again    = 1'b0;
    have_res = 1'b0;
    do_tok   = 1'b0;
    do_err   = 1'b0;
    tok_kind = sts_pkg::KIND_END;
    err_code = sts_pkg::ERR_NONE;

    if (eoi_i) begin
      if (!cur_i.err_latched) begin
        unique case (cur_i.mode)
          sts_pkg::MODE_COMMENT: begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_COMMENT;
          end
          sts_pkg::MODE_STRING: begin
            do_err = 1'b1; err_code = sts_pkg::ERR_EOF_STRING;
          end
          sts_pkg::MODE_INT, sts_pkg::MODE_HEX: begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_INT;
          end
          sts_pkg::MODE_HEX_START: begin
            do_err = 1'b1; err_code = sts_pkg::ERR_NO_HEX_DIGIT;
          end
          sts_pkg::MODE_FRAC_START: begin
            do_err = 1'b1; err_code = sts_pkg::ERR_NO_FRACTION;
          end
          sts_pkg::MODE_FRAC, sts_pkg::MODE_EXP: begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_DEC;
          end
          sts_pkg::MODE_EXP_START, sts_pkg::MODE_EXP_SIGN: begin
            do_err = 1'b1; err_code = sts_pkg::ERR_NO_EXP_DIGITS;
          end
          sts_pkg::MODE_IDENT: begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_IDENT;
          end
          default: ;
        endcase
      end
      if (do_tok) begin
        res[0] = '{kind: tok_kind, punct: 8'd0, length: cur_i.tok_bytes,
                   line: cur_i.tok_line, column: cur_i.tok_column,
                   err: sts_pkg::ERR_NONE, last: 1'b0};
        cnt = 2'd1;
      end else if (do_err) begin
        res[0] = '{kind: sts_pkg::KIND_ERROR, punct: 8'd0, length: 16'd0,
                   line: cur_i.line, column: cur_i.column, err: err_code, last: 1'b0};
        cnt = 2'd1;
      end
      res[cnt[0]] = '{kind: sts_pkg::KIND_END, punct: 8'd0, length: 16'd0,
                      line: cur_i.line, column: cur_i.column,
                      err: sts_pkg::ERR_NONE, last: 1'b1};
      cnt = cnt + 2'd1;
      s   = sts_pkg::StateReset;
    end else if (!cur_i.err_latched) begin
      if (char_i == 8'h0A) begin
        s.line   = sat_inc(cur_i.line);
        s.column = 16'd1;
      end else begin
        s.column = sat_inc(cur_i.column);
      end

      // Byte against the open token; again means it also starts what follows
      unique case (cur_i.mode)
        sts_pkg::MODE_IDLE: again = 1'b1;
        sts_pkg::MODE_COMMENT: begin
          if (char_i == 8'h0A) begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_COMMENT;
          end else begin
            s.tok_bytes = sat_inc(s.tok_bytes);
          end
        end
        sts_pkg::MODE_STRING: begin
          s.tok_bytes = sat_inc(s.tok_bytes);
          if (char_i == "\"") begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_STRING;
          end
        end
        sts_pkg::MODE_INT: begin
          if (cur_i.lead_zero && (cur_i.tok_bytes == 16'd1) && (char_i == "x")) begin
            s.mode = sts_pkg::MODE_HEX_START; s.tok_bytes = sat_inc(s.tok_bytes);
          end else if (is_digit(char_i)) begin
            s.tok_bytes = sat_inc(s.tok_bytes);
          end else if (char_i == ".") begin
            s.mode = sts_pkg::MODE_FRAC_START; s.tok_bytes = sat_inc(s.tok_bytes);
          end else if (char_i == "e") begin
            s.mode = sts_pkg::MODE_EXP_START; s.tok_bytes = sat_inc(s.tok_bytes);
          end else if (is_alpha(char_i)) begin
            do_err = 1'b1; err_code = sts_pkg::ERR_INT_LETTER;
          end else begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_INT; again = 1'b1;
          end
        end
        sts_pkg::MODE_HEX_START, sts_pkg::MODE_HEX: begin
          if (is_xdigit(char_i)) begin
            s.mode = sts_pkg::MODE_HEX; s.tok_bytes = sat_inc(s.tok_bytes);
          end else if (cur_i.mode == sts_pkg::MODE_HEX_START) begin
            do_err = 1'b1; err_code = sts_pkg::ERR_NO_HEX_DIGIT;
          end else begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_INT; again = 1'b1;
          end
        end
        sts_pkg::MODE_FRAC_START: begin
          if (is_digit(char_i)) begin
            s.mode = sts_pkg::MODE_FRAC; s.tok_bytes = sat_inc(s.tok_bytes);
          end else begin
            do_err = 1'b1; err_code = sts_pkg::ERR_NO_FRACTION;
          end
        end
        sts_pkg::MODE_FRAC: begin
          if (is_digit(char_i)) begin
            s.tok_bytes = sat_inc(s.tok_bytes);
          end else if (char_i == ".") begin
            do_err = 1'b1; err_code = sts_pkg::ERR_SECOND_POINT;
          end else if (char_i == "e") begin
            s.mode = sts_pkg::MODE_EXP_START; s.tok_bytes = sat_inc(s.tok_bytes);
          end else begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_DEC; again = 1'b1;
          end
        end
        sts_pkg::MODE_EXP_START, sts_pkg::MODE_EXP_SIGN: begin
          if (is_digit(char_i)) begin
            s.mode = sts_pkg::MODE_EXP; s.tok_bytes = sat_inc(s.tok_bytes);
          end else if ((cur_i.mode == sts_pkg::MODE_EXP_START) &&
                       ((char_i == "+") || (char_i == "-"))) begin
            s.mode = sts_pkg::MODE_EXP_SIGN; s.tok_bytes = sat_inc(s.tok_bytes);
          end else begin
            do_err = 1'b1; err_code = sts_pkg::ERR_NO_EXP_DIGITS;
          end
        end
        sts_pkg::MODE_EXP: begin
          if (is_digit(char_i)) begin
            s.tok_bytes = sat_inc(s.tok_bytes);
          end else begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_DEC; again = 1'b1;
          end
        end
        sts_pkg::MODE_IDENT: begin
          if (is_alpha(char_i) || is_digit(char_i) || (char_i == ".")) begin
            s.tok_bytes = sat_inc(s.tok_bytes);
          end else begin
            do_tok = 1'b1; tok_kind = sts_pkg::KIND_IDENT; again = 1'b1;
          end
        end
        default: begin
          s.mode = sts_pkg::MODE_IDLE; again = 1'b1;
        end
      endcase

      if (do_tok) begin
        res[0] = '{kind: tok_kind, punct: 8'd0, length: s.tok_bytes,
                   line: s.tok_line, column: s.tok_column,
                   err: sts_pkg::ERR_NONE, last: 1'b0};
        cnt = 2'd1;
        s.mode = sts_pkg::MODE_IDLE; s.tok_bytes = 16'd0; s.lead_zero = 1'b0;
      end else if (do_err) begin
        res[0] = '{kind: sts_pkg::KIND_ERROR, punct: 8'd0, length: 16'd0,
                   line: ln, column: col, err: err_code, last: 1'b0};
        cnt = 2'd1;
        s.err_latched = 1'b1;
        s.mode = sts_pkg::MODE_IDLE; s.tok_bytes = 16'd0; s.lead_zero = 1'b0;
      end

      if (again && !s.err_latched && !is_space(char_i)) begin
        priority if (char_i == "|") begin
          s.mode = sts_pkg::MODE_COMMENT;
        end else if (char_i == "\"") begin
          s.mode = sts_pkg::MODE_STRING;
        end else if (is_digit(char_i)) begin
          s.mode = sts_pkg::MODE_INT;
        end else if (char_i == ".") begin
          s.mode = sts_pkg::MODE_FRAC_START;
        end else if (is_alpha(char_i)) begin
          s.mode = sts_pkg::MODE_IDENT;
        end else if (is_punct(char_i)) begin
          r = '{kind: sts_pkg::KIND_PUNCT, punct: char_i, length: 16'd1,
                line: ln, column: col, err: sts_pkg::ERR_NONE, last: 1'b0};
          have_res = 1'b1;
        end else begin
          r = '{kind: sts_pkg::KIND_ERROR, punct: 8'd0, length: 16'd0,
                line: ln, column: col, err: sts_pkg::ERR_BAD_CHAR, last: 1'b0};
          have_res = 1'b1;
          s.err_latched = 1'b1;
          s.mode = sts_pkg::MODE_IDLE; s.tok_bytes = 16'd0; s.lead_zero = 1'b0;
        end
        if (!have_res) begin
          s.tok_line   = ln;
          s.tok_column = col;
          s.tok_bytes  = 16'd1;
          s.lead_zero  = (char_i == "0");
        end else begin
          res[cnt[0]] = r;
          cnt = cnt + 2'd1;
        end
      end

      if (cnt == 2'd1) begin
        res[0].last = 1'b1;
      end else if (cnt == 2'd2) begin
        res[1].last = 1'b1;
      end
    end

    nxt_o = s;
    out_o = '{count: cnt, res1: res[1], res0: res[0]};
  end

endmodule

### hdl/sts_result_fifo.sv
// ----------------------------------------------------------------------------
// sts_result_fifo
// Result queue taking up to two results per cycle, delivering one.
// ----------------------------------------------------------------------------
module sts_result_fifo #(
  parameter int unsigned Depth = sts_pkg::ResultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  sts_pkg::step_out_t wr_i,
  output logic               full_o,
  output logic               rd_valid_o,
  input  logic               rd_en_i,
  output sts_pkg::result_t   rd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] Limit = CntW'(Depth - 2);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  sts_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PtrW-1:0]  wr_ptr_nx;
  logic [1:0]       n_wr;
  logic             do_rd;

  assign wr_ptr_nx  = ptr_inc(wr_ptr_q);
  assign n_wr       = wr_en_i ? wr_i.count : 2'd0;
  assign do_rd      = rd_en_i && (count_q != '0);
  assign full_o     = count_q > Limit;
  assign rd_valid_o = count_q != '0;
  assign rd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (n_wr == 2'd1) begin
      wr_ptr_d = wr_ptr_nx;
    end else if (n_wr == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end
    rd_ptr_d = do_rd ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(n_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.res0;
    end
    if (n_wr == 2'd2) begin
      mem_q[wr_ptr_nx] <= wr_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hdl/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the source token scanner core.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_input_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  token_kind_o,
  input logic [7:0]  punct_char_o,
  input logic [15:0] token_length_o,
  input logic [2:0]  error_code_o,
  input logic        last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_length_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != sts_pkg::KIND_ERROR) |-> error_code_o == 3'd0)
    else $error("error code on a non-error result");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == sts_pkg::KIND_END) |-> last_of_run_o)
    else $error("end result not last of its run");

  a_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != sts_pkg::KIND_PUNCT) |-> punct_char_o == 8'd0)
    else $error("punctuation byte on another kind");

  a_eoi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_input_i |=> out_valid_o)
    else $error("no result after end-of-input transfer");

endmodule

bind source_token_scanner_core sts_checker u_sts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .end_of_input_i (end_of_input_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .punct_char_o   (punct_char_o),
  .token_length_o (token_length_o),
  .error_code_o   (error_code_o),
  .last_of_run_o  (last_of_run_o)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for source_token_scanner_core. Byte streams are scanned
// by a behavioural predictor held in the bench, and every result transfer is
// checked field by field against the oldest predicted token. Directed streams
// cover each token class, each error code and end-of-input closing. A random
// stream of mostly well-formed tokens mixed with noise follows. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i      = 8'd0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  token_kind_o;
  logic [7:0]  punct_char_o;
  logic [15:0] token_length_o;
  logic [15:0] start_line_o;
  logic [15:0] start_column_o;
  logic [2:0]  error_code_o;
  logic        last_of_run_o;

  source_token_scanner_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .punct_char_o   (punct_char_o),
    .token_length_o (token_length_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // scanner state as predicted
  sts_pkg::mode_e sc_mode;
  logic [15:0]    sc_line, sc_col, sc_tok_line, sc_tok_col, sc_tok_len;
  logic           sc_lead_zero, sc_err_hold;

  sts_pkg::result_t step_buf [2];
  int               step_n;
  sts_pkg::result_t expected_tokens [$];

  sts_pkg::result_t got, want;
  int      mismatches = 0;
  int      items_sent = 0;
  bit      feed_gaps  = 1'b1;
  bit      stall_gaps = 1'b1;

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    case (c)
      "%", "&", "(", ")", "*", "+", ",", "-", ".", "/", ":", ";", "<", "=", ">",
      "?", "[", "\\", "]", "^", "{", "}": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic queue_token(sts_pkg::result_t t);
    expected_tokens = {expected_tokens, t};
  endtask

  task automatic scanner_reset();
    sc_mode      = sts_pkg::MODE_IDLE;
    sc_line      = 16'd1;
    sc_col       = 16'd1;
    sc_tok_line  = 16'd1;
    sc_tok_col   = 16'd1;
    sc_tok_len   = 16'd0;
    sc_lead_zero = 1'b0;
    sc_err_hold  = 1'b0;
  endtask

  task automatic push_result(sts_pkg::kind_e k, logic [7:0] pc, logic [15:0] len,
                             logic [15:0] ln, logic [15:0] col, sts_pkg::err_e e);
    step_buf[step_n] = '{kind: k, punct: pc, length: len, line: ln, column: col,
                         err: e, last: 1'b0};
    step_n++;
  endtask

  task automatic finish_token(sts_pkg::kind_e k);
    push_result(k, 8'd0, sc_tok_len, sc_tok_line, sc_tok_col, sts_pkg::ERR_NONE);
    sc_mode      = sts_pkg::MODE_IDLE;
    sc_tok_len   = 16'd0;
    sc_lead_zero = 1'b0;
  endtask

  task automatic raise_error(sts_pkg::err_e e, logic [15:0] ln, logic [15:0] col);
    push_result(sts_pkg::KIND_ERROR, 8'd0, 16'd0, ln, col, e);
    sc_err_hold  = 1'b1;
    sc_mode      = sts_pkg::MODE_IDLE;
    sc_tok_len   = 16'd0;
    sc_lead_zero = 1'b0;
  endtask

  task automatic open_token(sts_pkg::mode_e m, logic [15:0] ln, logic [15:0] col);
    sc_mode      = m;
    sc_tok_line  = ln;
    sc_tok_col   = col;
    sc_tok_len   = 16'd1;
    sc_lead_zero = 1'b0;
  endtask

  task automatic scan_idle(logic [7:0] c, logic [15:0] ln, logic [15:0] col);
    if (!is_ws(c)) begin
      if (c == "|") begin
        open_token(sts_pkg::MODE_COMMENT, ln, col);
      end else if (c == "\"") begin
        open_token(sts_pkg::MODE_STRING, ln, col);
      end else if (is_dig(c)) begin
        open_token(sts_pkg::MODE_INT, ln, col);
        sc_lead_zero = (c == "0");
      end else if (c == ".") begin
        open_token(sts_pkg::MODE_FRAC_START, ln, col);
      end else if (is_alpha(c)) begin
        open_token(sts_pkg::MODE_IDENT, ln, col);
      end else if (is_punct(c)) begin
        push_result(sts_pkg::KIND_PUNCT, c, 16'd1, ln, col, sts_pkg::ERR_NONE);
      end else begin
        raise_error(sts_pkg::ERR_BAD_CHAR, ln, col);
      end
    end
  endtask

  // reuse: the byte ended the token and starts whatever follows it
  task automatic scan_in_token(logic [7:0] c, logic [15:0] ln, logic [15:0] col,
                               output bit reuse);
    bit grow;
    reuse = 1'b0;
    grow  = 1'b1;
    case (sc_mode)
      sts_pkg::MODE_COMMENT: begin
        if (c == "\n") finish_token(sts_pkg::KIND_COMMENT);
        else sc_tok_len = sat_inc16(sc_tok_len);
      end
      sts_pkg::MODE_STRING: begin
        sc_tok_len = sat_inc16(sc_tok_len);
        if (c == "\"") finish_token(sts_pkg::KIND_STRING);
      end
      sts_pkg::MODE_INT: begin
        if (sc_lead_zero && sc_tok_len == 16'd1 && c == "x") begin
          sc_mode = sts_pkg::MODE_HEX_START;
        end else if (c == ".") begin
          sc_mode = sts_pkg::MODE_FRAC_START;
        end else if (c == "e") begin
          sc_mode = sts_pkg::MODE_EXP_START;
        end else if (is_alpha(c)) begin
          raise_error(sts_pkg::ERR_INT_LETTER, ln, col);
          grow = 1'b0;
        end else if (!is_dig(c)) begin
          finish_token(sts_pkg::KIND_INT);
          reuse = 1'b1;
          grow  = 1'b0;
        end
        if (grow) sc_tok_len = sat_inc16(sc_tok_len);
      end
      sts_pkg::MODE_HEX_START, sts_pkg::MODE_HEX: begin
        if (is_hex(c)) begin
          sc_mode    = sts_pkg::MODE_HEX;
          sc_tok_len = sat_inc16(sc_tok_len);
        end else if (sc_mode == sts_pkg::MODE_HEX_START) begin
          raise_error(sts_pkg::ERR_NO_HEX_DIGIT, ln, col);
        end else begin
          finish_token(sts_pkg::KIND_INT);
          reuse = 1'b1;
        end
      end
      sts_pkg::MODE_FRAC_START: begin
        if (is_dig(c)) begin
          sc_mode    = sts_pkg::MODE_FRAC;
          sc_tok_len = sat_inc16(sc_tok_len);
        end else begin
          raise_error(sts_pkg::ERR_NO_FRACTION, ln, col);
        end
      end
      sts_pkg::MODE_FRAC: begin
        if (c == ".") begin
          raise_error(sts_pkg::ERR_SECOND_POINT, ln, col);
          grow = 1'b0;
        end else if (c == "e") begin
          sc_mode = sts_pkg::MODE_EXP_START;
        end else if (!is_dig(c)) begin
          finish_token(sts_pkg::KIND_DEC);
          reuse = 1'b1;
          grow  = 1'b0;
        end
        if (grow) sc_tok_len = sat_inc16(sc_tok_len);
      end
      sts_pkg::MODE_EXP_START, sts_pkg::MODE_EXP_SIGN: begin
        if (is_dig(c)) begin
          sc_mode    = sts_pkg::MODE_EXP;
          sc_tok_len = sat_inc16(sc_tok_len);
        end else if (sc_mode == sts_pkg::MODE_EXP_START && (c == "+" || c == "-")) begin
          sc_mode    = sts_pkg::MODE_EXP_SIGN;
          sc_tok_len = sat_inc16(sc_tok_len);
        end else begin
          raise_error(sts_pkg::ERR_NO_EXP_DIGITS, ln, col);
        end
      end
      sts_pkg::MODE_EXP: begin
        if (is_dig(c)) begin
          sc_tok_len = sat_inc16(sc_tok_len);
        end else begin
          finish_token(sts_pkg::KIND_DEC);
          reuse = 1'b1;
        end
      end
      sts_pkg::MODE_IDENT: begin
        if (is_alpha(c) || is_dig(c) || c == ".") begin
          sc_tok_len = sat_inc16(sc_tok_len);
        end else begin
          finish_token(sts_pkg::KIND_IDENT);
          reuse = 1'b1;
        end
      end
      default: begin
        sc_mode = sts_pkg::MODE_IDLE;
        reuse   = 1'b1;
      end
    endcase
  endtask

  task automatic close_stream();
    case (sc_mode)
      sts_pkg::MODE_COMMENT:
        finish_token(sts_pkg::KIND_COMMENT);
      sts_pkg::MODE_STRING:
        raise_error(sts_pkg::ERR_EOF_STRING, sc_line, sc_col);
      sts_pkg::MODE_INT, sts_pkg::MODE_HEX:
        finish_token(sts_pkg::KIND_INT);
      sts_pkg::MODE_HEX_START:
        raise_error(sts_pkg::ERR_NO_HEX_DIGIT, sc_line, sc_col);
      sts_pkg::MODE_FRAC_START:
        raise_error(sts_pkg::ERR_NO_FRACTION, sc_line, sc_col);
      sts_pkg::MODE_FRAC, sts_pkg::MODE_EXP:
        finish_token(sts_pkg::KIND_DEC);
      sts_pkg::MODE_EXP_START, sts_pkg::MODE_EXP_SIGN:
        raise_error(sts_pkg::ERR_NO_EXP_DIGITS, sc_line, sc_col);
      sts_pkg::MODE_IDENT:
        finish_token(sts_pkg::KIND_IDENT);
      default: ;
    endcase
  endtask

  task automatic predict_tokens(logic [7:0] c, logic eoi);
    logic [15:0] ln, col;
    bit          reuse;
    step_n = 0;
    if (eoi) begin
      if (!sc_err_hold) close_stream();
      push_result(sts_pkg::KIND_END, 8'd0, 16'd0, sc_line, sc_col, sts_pkg::ERR_NONE);
      scanner_reset();
    end else if (!sc_err_hold) begin
      ln  = sc_line;
      col = sc_col;
      if (c == "\n") begin
        sc_line = sat_inc16(sc_line);
        sc_col  = 16'd1;
      end else begin
        sc_col = sat_inc16(sc_col);
      end
      reuse = 1'b1;
      if (sc_mode != sts_pkg::MODE_IDLE) scan_in_token(c, ln, col, reuse);
      if (reuse && !sc_err_hold) scan_idle(c, ln, col);
    end
    if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) queue_token(step_buf[i]);
  endtask

  // ---- driving ----
  task automatic send_item(logic [7:0] c, logic eoi);
    @(negedge clk_i);
    while (feed_gaps && $urandom_range(0, 99) < 33) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    char_in_i      = c;
    end_of_input_i = eoi;
    do @(posedge clk_i); while (in_stall_o);
    predict_tokens(c, eoi);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic send_digits(int n);
    repeat (n) send_item(pick("0123456789"), 1'b0);
  endtask

  task automatic wait_all_tokens();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) out_stall_i = stall_gaps && ($urandom_range(0, 99) < 33);

  // ---- checking ----
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind: sts_pkg::kind_e'(token_kind_o), punct: punct_char_o,
              length: token_length_o, line: start_line_o, column: start_column_o,
              err: sts_pkg::err_e'(error_code_o), last: last_of_run_o};
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d line %0d col %0d err %0d",
                   got.kind, got.line, got.column, got.err);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.punct !== want.punct ||
            got.length !== want.length || got.line !== want.line ||
            got.column !== want.column || got.err !== want.err ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token mismatch: expected kind %0d punct %0d len %0d line %0d ",
                      "col %0d err %0d last %0d, got kind %0d punct %0d len %0d ",
                      "line %0d col %0d err %0d last %0d"},
                     want.kind, want.punct, want.length, want.line, want.column,
                     want.err, want.last, got.kind, got.punct, got.length,
                     got.line, got.column, got.err, got.last);
        end
      end
    end
  end

  // ---- tests ----
  task automatic test_token_classes();
    string closing [6] = '{"|tail", "0x1", "1.5", "3e4", "9", ""};
    send_text("|note\n\"a\nb\" 42 0x1fA 0 3.14 .5 2e9 7e+1 6.0e-3 1.5E a.b9 Zz");
    send_text("%&()*+,-/:;<=>?[\\]^{}");
    for (int w = 9; w <= 13; w++) send_item(8'(w), 1'b0);
    send_item(" ", 1'b0);
    foreach (closing[i]) begin
      send_text(closing[i]);
      send_eoi();
    end
  endtask

  task automatic test_error_codes();
    string broken [14] = '{"#abc", "\"ab", "12a", "5E", "0X", "1.a", ".", "1.2.3",
                           "1e+", "1ex", "1e", "2e-+", "0xg", "0x"};
    logic [7:0] bad [3] = '{8'h00, 8'h80, 8'hff};
    foreach (broken[i]) begin
      send_text(broken[i]);
      send_eoi();
    end
    foreach (bad[i]) begin
      send_item(bad[i], 1'b0);
      send_text("ok");
      send_eoi();
    end
  endtask

  task automatic send_random_token();
    int         sel;
    logic [7:0] c;
    sel = $urandom_range(0, 21);
    case (sel)
      0, 1: begin
        send_item("|", 1'b0);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom); while (c == 8'h0a);
          send_item(c, 1'b0);
        end
        send_item("\n", 1'b0);
      end
      2, 3: begin
        send_item("\"", 1'b0);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom); while (c == "\"");
          send_item(c, 1'b0);
        end
        send_item("\"", 1'b0);
      end
      4, 5: begin
        send_digits($urandom_range(1, 5));
        if ($urandom_range(0, 3) == 0) begin
          send_item("e", 1'b0);
          send_digits($urandom_range(1, 3));
        end
      end
      6: begin
        send_text("0x");
        repeat ($urandom_range(0, 4)) send_item(pick("0123456789abcdefABCDEF"), 1'b0);
      end
      7, 8: begin
        if ($urandom_range(0, 1)) send_digits($urandom_range(1, 3));
        send_item(".", 1'b0);
        send_digits($urandom_range(1, 3));
        if ($urandom_range(0, 1)) begin
          send_item("e", 1'b0);
          case ($urandom_range(0, 2))
            0: send_item("+", 1'b0);
            1: send_item("-", 1'b0);
            default: ;
          endcase
          send_digits($urandom_range(1, 3));
        end
      end
      9, 10: begin
        send_item(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"), 1'b0);
        repeat ($urandom_range(0, 5))
          send_item(pick("abexzAEXZ0159."), 1'b0);
      end
      11, 12: send_item(pick("%&()*+,-/:;<=>?[\\]^{}"), 1'b0);
      13:     send_item(8'(pick("9abcd ") == " " ? " " : $urandom_range(9, 13)), 1'b0);
      14:     send_item(8'($urandom), 1'b0);
      15, 16, 17: send_eoi();
      default: begin
        case ($urandom_range(0, 9))
          0: send_text("1.");
          1: send_text("1e");
          2: send_text("1e+");
          3: send_text("0x");
          4: send_text("1.2.");
          5: send_text("12a");
          6: send_text("0X");
          7: send_text(".x");
          8: send_text("\"open");
          default: send_text("5E");
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) send_item(pick(" \n\t"), 1'b0);
  endtask

  task automatic test_random_stream();
    bit paused;
    paused     = 1'b0;
    items_sent = 0;
    while (items_sent < 680) begin
      feed_gaps  = !(items_sent >= 250 && items_sent < 420);
      stall_gaps = feed_gaps;
      if (!paused && items_sent >= 500) begin
        wait_all_tokens();
        paused = 1'b1;
      end
      send_random_token();
    end
    send_eoi();
  endtask

  initial begin
    scanner_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_token_classes();
    test_error_codes();
    wait_all_tokens();
    test_random_stream();
    wait_all_tokens();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
hdl/sts_pkg.sv
hdl/sts_step.sv
hdl/sts_result_fifo.sv
hdl/source_token_scanner_core.sv
hdl/sts_checker.sv
bench/tb_top.sv
